/* rtl/core/tcp_header_parser_core_macros.svh */
// Assertion macros shared by the TCP header parser RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef TCP_HEADER_PARSER_CORE_MACROS_SVH
`define TCP_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCPHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcphp check failed");

// Next-cycle implication, checked outside reset.
`define TCPHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcphp check failed");

`endif

/* rtl/core/tcphp_pkg.sv */
// Types and constants for the TCP header parser.
// Used by tcphp_step and tcp_header_parser_core; depends on nothing.
package tcphp_pkg;

  // Parse phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_FIXED     = 6'b000010,
    PH_KIND      = 6'b000100,
    PH_LEN       = 6'b001000,
    PH_VAL_KNOWN = 6'b010000,
    PH_VAL_UNK   = 6'b100000
  } phase_t;

  // Record types on the result channel.
  typedef enum logic [3:0] {
    REC_BASE      = 4'd0,
    REC_EOL       = 4'd1,
    REC_NOP       = 4'd2,
    REC_MSS       = 4'd3,
    REC_WSCALE    = 4'd4,
    REC_SACK_PERM = 4'd5,
    REC_SACK_BLK  = 4'd6,
    REC_TSTAMP    = 4'd7,
    REC_UNK_HDR   = 4'd8,
    REC_UNK_BYTE  = 4'd9,
    REC_TRUNC     = 4'd10
  } rec_type_t;

  // Option kind codes.
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SPERM  = 8'd4;
  localparam logic [7:0] KIND_SACK   = 8'd5;
  localparam logic [7:0] KIND_TSTAMP = 8'd8;

  // Fixed header layout.
  localparam logic [5:0] POS_SEQ      = 6'd4;
  localparam logic [5:0] POS_ACK      = 6'd8;
  localparam logic [5:0] POS_OFFSET   = 6'd12;
  localparam logic [5:0] POS_FIX_LAST = 6'd19;
  localparam logic [5:0] FIX_HDR_LEN  = 6'd20;

  // Running parser state.
  typedef struct packed {
    phase_t       phase;
    logic [5:0]   byte_pos;
    logic [5:0]   hdr_bytes;
    logic [31:0]  port_pair;
    logic [31:0]  seq_hold;
    logic [31:0]  ack_hold;
    logic [55:0]  misc_hold;
    logic [7:0]   cur_kind;
    logic [7:0]   cur_len;
    logic [7:0]   opt_cnt;
    logic [63:0]  accum;
  } state_t;

  localparam state_t STATE_RST = '{
    phase:     PH_IDLE,
    byte_pos:  6'd0,
    hdr_bytes: 6'd0,
    port_pair: 32'd0,
    seq_hold:  32'd0,
    ack_hold:  32'd0,
    misc_hold: 56'd0,
    cur_kind:  8'd0,
    cur_len:   8'd0,
    opt_cnt:   8'd0,
    accum:     64'd0
  };

  // One result record.
  typedef struct packed {
    rec_type_t    rtype;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
    logic [31:0]  word_a;
    logic [31:0]  word_b;
    logic [7:0]   flag_bits;
    logic [15:0]  window;
    logic [15:0]  urgent_ptr;
    logic [15:0]  checksum;
    logic [7:0]   length;
    logic [7:0]   option_kind;
    logic         last;
  } rec_t;

endpackage

/* rtl/core/tcphp_step.sv */
// Next-state and record logic for one header byte of the TCP header parser.
// Depends on tcphp_pkg.
module tcphp_step (
  input  tcphp_pkg::state_t cur,
  input  logic [7:0]        data_byte,
  input  logic              segment_start,
  output tcphp_pkg::state_t nxt,
  output logic              emit,
  output tcphp_pkg::rec_t   rec
);

  tcphp_pkg::state_t s;
  logic [5:0]  pos;
  logic        final_byte;
  logic        complete;
  logic        len_ok;
  logic [7:0]  cnt_inc;
  logic [63:0] acc_sh;
  logic        cnt_done;

  always_comb begin
    s          = cur;
    pos        = cur.byte_pos;
    final_byte = 1'b0;
    complete   = 1'b0;
    len_ok     = 1'b0;
    cnt_inc    = cur.opt_cnt + 8'd1;
    acc_sh     = {cur.accum[55:0], data_byte};
    cnt_done   = ({1'b0, cnt_inc} + 9'd2) >= {1'b0, cur.cur_len};
    emit       = 1'b0;
    rec        = '0;

    // A start byte always opens a fresh header.
    if (segment_start) begin
      s       = tcphp_pkg::STATE_RST;
      s.phase = tcphp_pkg::PH_FIXED;
    end
    pos = s.byte_pos;

    if (s.phase == tcphp_pkg::PH_FIXED) begin
      // Shift the byte into the fixed-header field it belongs to.
      if (pos < tcphp_pkg::POS_SEQ) begin
        s.port_pair = {s.port_pair[23:0], data_byte};
      end else if (pos < tcphp_pkg::POS_ACK) begin
        s.seq_hold = {s.seq_hold[23:0], data_byte};
      end else if (pos < tcphp_pkg::POS_OFFSET) begin
        s.ack_hold = {s.ack_hold[23:0], data_byte};
      end else if (pos == tcphp_pkg::POS_OFFSET) begin
        s.hdr_bytes = {data_byte[7:4], 2'b00};
      end else begin
        s.misc_hold = {s.misc_hold[47:0], data_byte};
      end
      s.byte_pos = pos + 6'd1;

      // The last fixed byte releases the base record.
      if (pos == tcphp_pkg::POS_FIX_LAST) begin
        emit            = 1'b1;
        rec.rtype       = tcphp_pkg::REC_BASE;
        rec.src_port    = s.port_pair[31:16];
        rec.dst_port    = s.port_pair[15:0];
        rec.word_a      = s.seq_hold;
        rec.word_b      = s.ack_hold;
        rec.flag_bits   = s.misc_hold[55:48];
        rec.window      = s.misc_hold[47:32];
        rec.checksum    = s.misc_hold[31:16];
        rec.urgent_ptr  = s.misc_hold[15:0];
        rec.length      = {2'b00, s.hdr_bytes};
        rec.option_kind = 8'd0;
        rec.last        = (s.hdr_bytes <= tcphp_pkg::FIX_HDR_LEN);
        s.phase         = rec.last ? tcphp_pkg::PH_IDLE : tcphp_pkg::PH_KIND;
      end
    end else if (s.phase != tcphp_pkg::PH_IDLE) begin
      final_byte = ({1'b0, pos} + 7'd1) >= {1'b0, s.hdr_bytes};

      case (s.phase)
        tcphp_pkg::PH_KIND: begin
          s.cur_kind = data_byte;
          s.cur_len  = 8'd0;
          if (data_byte == tcphp_pkg::KIND_EOL) begin
            rec.rtype = tcphp_pkg::REC_EOL;
            s.cur_len = 8'd1;
            emit      = 1'b1;
            complete  = 1'b1;
          end else if (data_byte == tcphp_pkg::KIND_NOP) begin
            rec.rtype = tcphp_pkg::REC_NOP;
            s.cur_len = 8'd1;
            emit      = 1'b1;
            complete  = 1'b1;
          end else begin
            s.phase = tcphp_pkg::PH_LEN;
          end
        end

        tcphp_pkg::PH_LEN: begin
          // Known options must carry their exact length; SACK needs two plus a nonzero multiple of eight.
          len_ok = (s.cur_kind == tcphp_pkg::KIND_MSS    && data_byte == 8'd4)  ||
                   (s.cur_kind == tcphp_pkg::KIND_WSCALE && data_byte == 8'd3)  ||
                   (s.cur_kind == tcphp_pkg::KIND_SPERM  && data_byte == 8'd2)  ||
                   (s.cur_kind == tcphp_pkg::KIND_TSTAMP && data_byte == 8'd10) ||
                   (s.cur_kind == tcphp_pkg::KIND_SACK && data_byte > 8'd2 &&
                    data_byte[2:0] == 3'd2);
          s.cur_len = data_byte;
          s.opt_cnt = 8'd0;
          s.accum   = 64'd0;
          if (len_ok && s.cur_kind == tcphp_pkg::KIND_SPERM) begin
            rec.rtype = tcphp_pkg::REC_SACK_PERM;
            emit      = 1'b1;
            complete  = 1'b1;
          end else if (len_ok) begin
            s.phase = tcphp_pkg::PH_VAL_KNOWN;
          end else begin
            rec.rtype = tcphp_pkg::REC_UNK_HDR;
            emit      = 1'b1;
            if (data_byte <= 8'd2) begin
              complete = 1'b1;
            end else begin
              s.phase = tcphp_pkg::PH_VAL_UNK;
            end
          end
        end

        tcphp_pkg::PH_VAL_KNOWN: begin
          s.accum   = acc_sh;
          s.opt_cnt = cnt_inc;
          if (s.cur_kind == tcphp_pkg::KIND_MSS && cnt_inc == 8'd2) begin
            rec.rtype  = tcphp_pkg::REC_MSS;
            rec.word_a = {16'd0, acc_sh[15:0]};
            emit       = 1'b1;
            complete   = 1'b1;
          end else if (s.cur_kind == tcphp_pkg::KIND_WSCALE) begin
            rec.rtype  = tcphp_pkg::REC_WSCALE;
            rec.word_a = {24'd0, data_byte};
            emit       = 1'b1;
            complete   = 1'b1;
          end else if (s.cur_kind == tcphp_pkg::KIND_TSTAMP && cnt_inc == 8'd8) begin
            rec.rtype  = tcphp_pkg::REC_TSTAMP;
            rec.word_a = acc_sh[63:32];
            rec.word_b = acc_sh[31:0];
            emit       = 1'b1;
            complete   = 1'b1;
          end else if (s.cur_kind == tcphp_pkg::KIND_SACK && cnt_inc[2:0] == 3'd0) begin
            // Every eight value bytes make one SACK block.
            rec.rtype  = tcphp_pkg::REC_SACK_BLK;
            rec.word_a = acc_sh[63:32];
            rec.word_b = acc_sh[31:0];
            emit       = 1'b1;
            complete   = cnt_done;
          end
        end

        tcphp_pkg::PH_VAL_UNK: begin
          s.opt_cnt  = cnt_inc;
          rec.rtype  = tcphp_pkg::REC_UNK_BYTE;
          rec.word_a = {24'd0, data_byte};
          emit       = 1'b1;
          complete   = cnt_done;
        end

        default: begin
          emit = 1'b0;
        end
      endcase

      if (complete) begin
        s.phase = tcphp_pkg::PH_KIND;
      end
      s.byte_pos = pos + 6'd1;

      // The final header byte closes parsing; an open option is truncated.
      if (final_byte) begin
        if (!complete) begin
          rec.rtype  = tcphp_pkg::REC_TRUNC;
          rec.word_a = 32'd0;
          rec.word_b = 32'd0;
          emit       = 1'b1;
        end
        s.phase = tcphp_pkg::PH_IDLE;
      end
      rec.length      = s.cur_len;
      rec.option_kind = s.cur_kind;
      rec.last        = final_byte;
    end

    nxt = s;
  end

endmodule

/* rtl/core/tcp_header_parser_core.sv */
// Top level of the TCP header parser: input register, step logic, result register.
// Depends on tcphp_pkg, tcphp_step and tcp_header_parser_core_macros.svh.
// A byte is held in the input register, runs through the step logic, and its record is loaded into the result register.
// Throughput: one header byte per cycle while the result side does not stall; the step logic is combinational.
// A stalled result holds the output register; the input register then fills and stalls.
// Reset (rst_n low, synchronous) empties both registers and puts the parser in idle.
`include "tcp_header_parser_core_macros.svh"

module tcp_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_segment_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_record_type,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [31:0] out_word_a,
  output logic [31:0] out_word_b,
  output logic [7:0]  out_flag_bits,
  output logic [15:0] out_window,
  output logic [15:0] out_urgent_ptr,
  output logic [15:0] out_checksum,
  output logic [7:0]  out_length,
  output logic [7:0]  out_option_kind,
  output logic        out_last
);

  tcphp_pkg::state_t state_r;
  tcphp_pkg::state_t state_nxt;
  tcphp_pkg::rec_t   rec_nxt;
  tcphp_pkg::rec_t   out_rec_r;
  logic              s0_valid_r;
  logic [7:0]        s0_byte_r;
  logic              s0_start_r;
  logic              out_valid_r;
  logic              emit;
  logic              out_free;
  logic              advance;

  // The output register can load when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s0_valid_r && out_free;
  assign in_stall = s0_valid_r && !out_free;

  tcphp_step u_step (
    .cur           (state_r),
    .data_byte     (s0_byte_r),
    .segment_start (s0_start_r),
    .nxt           (state_nxt),
    .emit          (emit),
    .rec           (rec_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s0_byte_r  <= in_data_byte;
      s0_start_r <= in_segment_start;
    end
  end

  // Parser state moves on once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcphp_pkg::STATE_RST;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_rec_r <= rec_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_record_type = out_rec_r.rtype;
  assign out_src_port    = out_rec_r.src_port;
  assign out_dst_port    = out_rec_r.dst_port;
  assign out_word_a      = out_rec_r.word_a;
  assign out_word_b      = out_rec_r.word_b;
  assign out_flag_bits   = out_rec_r.flag_bits;
  assign out_window      = out_rec_r.window;
  assign out_urgent_ptr  = out_rec_r.urgent_ptr;
  assign out_checksum    = out_rec_r.checksum;
  assign out_length      = out_rec_r.length;
  assign out_option_kind = out_rec_r.option_kind;
  assign out_last        = out_rec_r.last;

  // The input side only stalls when both registers are occupied.
  `TCPHP_ASSERT_NOW(a_stall_full, in_stall, s0_valid_r && out_valid_r)
  // A record that completes the header leaves the parser idle.
  `TCPHP_ASSERT_NEXT(a_last_idle, advance && emit && rec_nxt.last,
    state_r.phase == tcphp_pkg::PH_IDLE)
  // A truncated record always completes the header.
  `TCPHP_ASSERT_NOW(a_trunc_last,
    out_valid_r && out_rec_r.rtype == tcphp_pkg::REC_TRUNC, out_rec_r.last)
  // Base records carry no option kind.
  `TCPHP_ASSERT_NOW(a_base_kind,
    out_valid_r && out_rec_r.rtype == tcphp_pkg::REC_BASE, out_rec_r.option_kind == 8'd0)

endmodule

/* tb/tcp_header_parser_core_tb.sv */
// Self-checking testbench for tcp_header_parser_core: a byte-level parser predictor
// in a scoreboard class, random header traffic, and random stalls on both channels.
// Depends on tcphp_pkg and the tcp_header_parser_core RTL.
module tcp_header_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_PCT      = 7;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int BYTE_TARGET    = 1800;
  localparam int REPORT_MAX     = 10;

  // Predicts the parser records from the accepted header bytes and checks the
  // records that come out against them in order.
  class header_record_board;
    tcphp_pkg::phase_t phase;
    logic [5:0]        byte_pos;
    logic [5:0]        hdr_bytes;
    logic [31:0]       ports;
    logic [31:0]       seq_num;
    logic [31:0]       ack_num;
    logic [55:0]       misc;
    logic [7:0]        kind;
    logic [7:0]        opt_len;
    logic [7:0]        opt_cnt;
    logic [63:0]       accum;
    tcphp_pkg::rec_t   expected_recs[$];
    int                fail_count;
    int                report_count;

    function new();
      fail_count = 0;
      report_count = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = tcphp_pkg::PH_IDLE;
      byte_pos = '0;
      hdr_bytes = '0;
      ports = '0;
      seq_num = '0;
      ack_num = '0;
      misc = '0;
      kind = '0;
      opt_len = '0;
      opt_cnt = '0;
      accum = '0;
    endfunction

    function int outstanding();
      return expected_recs.size();
    endfunction

    // Runs one accepted request through the parser. Returns 1 when the byte
    // belongs to a header, 0 when the parser ignores it.
    function bit note_byte(logic [7:0] b, logic s);
      tcphp_pkg::rec_t r;
      bit              emit;
      bit              done;
      bit              fin;
      bit              ok;
      logic [5:0]      pos;
      r = '0;
      emit = 1'b0;
      done = 1'b0;
      if (s) begin
        clear_parse();
        phase = tcphp_pkg::PH_FIXED;
      end else if (phase == tcphp_pkg::PH_IDLE) begin
        return 1'b0;
      end
      pos = byte_pos;

      // Fixed header: collect fields, emit the base record on its last byte.
      if (phase == tcphp_pkg::PH_FIXED) begin
        if (pos < tcphp_pkg::POS_SEQ) ports = {ports[23:0], b};
        else if (pos < tcphp_pkg::POS_ACK) seq_num = {seq_num[23:0], b};
        else if (pos < tcphp_pkg::POS_OFFSET) ack_num = {ack_num[23:0], b};
        else if (pos == tcphp_pkg::POS_OFFSET) hdr_bytes = {b[7:4], 2'b00};
        else misc = {misc[47:0], b};
        byte_pos = pos + 6'd1;
        if (pos == tcphp_pkg::POS_FIX_LAST) begin
          r.rtype = tcphp_pkg::REC_BASE;
          r.src_port = ports[31:16];
          r.dst_port = ports[15:0];
          r.word_a = seq_num;
          r.word_b = ack_num;
          r.flag_bits = misc[55:48];
          r.window = misc[47:32];
          r.checksum = misc[31:16];
          r.urgent_ptr = misc[15:0];
          r.length = {2'b00, hdr_bytes};
          r.last = (hdr_bytes <= tcphp_pkg::FIX_HDR_LEN);
          phase = r.last ? tcphp_pkg::PH_IDLE : tcphp_pkg::PH_KIND;
          expected_recs.push_back(r);
        end
        return 1'b1;
      end

      // Option area.
      fin = (int'(pos) + 1 >= int'(hdr_bytes));
      case (phase)
        tcphp_pkg::PH_KIND: begin
          kind = b;
          opt_len = '0;
          if (b == tcphp_pkg::KIND_EOL || b == tcphp_pkg::KIND_NOP) begin
            r.rtype = (b == tcphp_pkg::KIND_EOL) ? tcphp_pkg::REC_EOL : tcphp_pkg::REC_NOP;
            opt_len = 8'd1;
            emit = 1'b1;
            done = 1'b1;
          end else begin
            phase = tcphp_pkg::PH_LEN;
          end
        end
        tcphp_pkg::PH_LEN: begin
          ok = (kind == tcphp_pkg::KIND_MSS && b == 8'd4) ||
               (kind == tcphp_pkg::KIND_WSCALE && b == 8'd3) ||
               (kind == tcphp_pkg::KIND_SPERM && b == 8'd2) ||
               (kind == tcphp_pkg::KIND_TSTAMP && b == 8'd10) ||
               (kind == tcphp_pkg::KIND_SACK && b > 8'd2 && b[2:0] == 3'd2);
          opt_len = b;
          opt_cnt = '0;
          accum = '0;
          if (ok && kind == tcphp_pkg::KIND_SPERM) begin
            r.rtype = tcphp_pkg::REC_SACK_PERM;
            emit = 1'b1;
            done = 1'b1;
          end else if (ok) begin
            phase = tcphp_pkg::PH_VAL_KNOWN;
          end else begin
            r.rtype = tcphp_pkg::REC_UNK_HDR;
            emit = 1'b1;
            if (b <= 8'd2) done = 1'b1;
            else phase = tcphp_pkg::PH_VAL_UNK;
          end
        end
        tcphp_pkg::PH_VAL_KNOWN: begin
          accum = {accum[55:0], b};
          opt_cnt = opt_cnt + 8'd1;
          if (kind == tcphp_pkg::KIND_MSS && opt_cnt == 8'd2) begin
            r.rtype = tcphp_pkg::REC_MSS;
            r.word_a = {16'h0, accum[15:0]};
            emit = 1'b1;
            done = 1'b1;
          end else if (kind == tcphp_pkg::KIND_WSCALE) begin
            r.rtype = tcphp_pkg::REC_WSCALE;
            r.word_a = {24'h0, b};
            emit = 1'b1;
            done = 1'b1;
          end else if (kind == tcphp_pkg::KIND_TSTAMP && opt_cnt == 8'd8) begin
            r.rtype = tcphp_pkg::REC_TSTAMP;
            r.word_a = accum[63:32];
            r.word_b = accum[31:0];
            emit = 1'b1;
            done = 1'b1;
          end else if (kind == tcphp_pkg::KIND_SACK && opt_cnt[2:0] == 3'd0) begin
            r.rtype = tcphp_pkg::REC_SACK_BLK;
            r.word_a = accum[63:32];
            r.word_b = accum[31:0];
            emit = 1'b1;
            done = (int'(opt_cnt) + 2 >= int'(opt_len));
          end
        end
        default: begin
          opt_cnt = opt_cnt + 8'd1;
          r.rtype = tcphp_pkg::REC_UNK_BYTE;
          r.word_a = {24'h0, b};
          emit = 1'b1;
          done = (int'(opt_cnt) + 2 >= int'(opt_len));
        end
      endcase
      if (done) phase = tcphp_pkg::PH_KIND;
      byte_pos = pos + 6'd1;

      // The last header byte closes the header; an open option is truncated.
      if (fin) begin
        if (!done) begin
          r.rtype = tcphp_pkg::REC_TRUNC;
          r.word_a = '0;
          r.word_b = '0;
          emit = 1'b1;
        end
        phase = tcphp_pkg::PH_IDLE;
      end
      if (emit) begin
        r.length = opt_len;
        r.option_kind = kind;
        r.last = fin;
        expected_recs.push_back(r);
      end
      return 1'b1;
    endfunction

    function string show(tcphp_pkg::rec_t r);
      return {$sformatf("type=%0d src=%h dst=%h a=%h b=%h flags=%h win=%h",
                        r.rtype, r.src_port, r.dst_port, r.word_a, r.word_b,
                        r.flag_bits, r.window),
              $sformatf(" urg=%h csum=%h len=%0d kind=%0d last=%b",
                        r.urgent_ptr, r.checksum, r.length, r.option_kind, r.last)};
    endfunction

    // Compares one accepted record with the oldest prediction.
    function void check_record(tcphp_pkg::rec_t got);
      tcphp_pkg::rec_t want;
      if (expected_recs.size() == 0) begin
        fail_count++;
        if (report_count < REPORT_MAX)
          $display("%0t: record with none predicted: %s", $realtime, show(got));
        report_count++;
        return;
      end
      want = expected_recs.pop_front();
      if (got.rtype !== want.rtype || got.src_port !== want.src_port ||
          got.dst_port !== want.dst_port || got.word_a !== want.word_a ||
          got.word_b !== want.word_b || got.flag_bits !== want.flag_bits ||
          got.window !== want.window || got.urgent_ptr !== want.urgent_ptr ||
          got.checksum !== want.checksum || got.length !== want.length ||
          got.option_kind !== want.option_kind || got.last !== want.last) begin
        fail_count++;
        if (report_count < REPORT_MAX) begin
          $display("%0t: record mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        report_count++;
      end
    endfunction

    // Predictions still waiting at the end are failures.
    function void flush_leftovers();
      if (expected_recs.size() != 0) begin
        $display("%0d predicted records never arrived", expected_recs.size());
        fail_count += expected_recs.size();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_segment_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_record_type;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [31:0] out_word_a;
  logic [31:0] out_word_b;
  logic [7:0]  out_flag_bits;
  logic [15:0] out_window;
  logic [15:0] out_urgent_ptr;
  logic [15:0] out_checksum;
  logic [7:0]  out_length;
  logic [7:0]  out_option_kind;
  logic        out_last;

  header_record_board board = new();
  logic [7:0]      hdr_q[$];
  bit              allow_idle = 1'b1;
  bit              hold_active = 1'b0;
  event            hold_go;
  int              bytes_sent = 0;
  int              quiet_cycles = 0;
  tcphp_pkg::rec_t seen;

  tcp_header_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_segment_start (in_segment_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_type  (out_record_type),
    .out_src_port     (out_src_port),
    .out_dst_port     (out_dst_port),
    .out_word_a       (out_word_a),
    .out_word_b       (out_word_b),
    .out_flag_bits    (out_flag_bits),
    .out_window       (out_window),
    .out_urgent_ptr   (out_urgent_ptr),
    .out_checksum     (out_checksum),
    .out_length       (out_length),
    .out_option_kind  (out_option_kind),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check each accepted record, then pick the next stall value.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{rtype: tcphp_pkg::rec_type_t'(out_record_type), src_port: out_src_port,
               dst_port: out_dst_port, word_a: out_word_a, word_b: out_word_b,
               flag_bits: out_flag_bits, window: out_window, urgent_ptr: out_urgent_ptr,
               checksum: out_checksum, length: out_length, option_kind: out_option_kind,
               last: out_last};
      board.check_record(seen);
    end
    out_stall <= hold_active || (allow_idle && $urandom_range(99) < STALL_PCT);
  end

  // Long receiver hold-off, counted here so the sender keeps offering requests.
  initial begin
    forever begin
      @(hold_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Ends the run when no request moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("tcp_header_parser_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte, with random gaps before it, and waits until it is taken.
  task automatic send_byte(input logic [7:0] d, input logic s);
    if (allow_idle) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_segment_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (board.note_byte(d, s)) bytes_sent++;
  endtask

  // Sender pause until every predicted record has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Twenty fixed header bytes: all zeros, all ones or random.
  task automatic put_fixed(input int mode);
    for (int i = 0; i < 20; i++) begin
      if (mode == 0) hdr_q.push_back(8'h00);
      else if (mode == 1) hdr_q.push_back(8'hFF);
      else hdr_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Appends one option; lengths and content follow the selected flavor.
  task automatic put_option(input int sel);
    int         n;
    logic [7:0] k;
    logic [7:0] l;
    n = 0;
    case (sel)
      0: hdr_q.push_back(tcphp_pkg::KIND_EOL);
      1: hdr_q.push_back(tcphp_pkg::KIND_NOP);
      2: begin
        hdr_q.push_back(tcphp_pkg::KIND_MSS);
        hdr_q.push_back(8'd4);
        n = 2;
      end
      3: begin
        hdr_q.push_back(tcphp_pkg::KIND_WSCALE);
        hdr_q.push_back(8'd3);
        n = 1;
      end
      4: begin
        hdr_q.push_back(tcphp_pkg::KIND_SPERM);
        hdr_q.push_back(8'd2);
      end
      5: begin
        n = 8 * $urandom_range(1, 4);
        hdr_q.push_back(tcphp_pkg::KIND_SACK);
        hdr_q.push_back(8'(n + 2));
      end
      6: begin
        hdr_q.push_back(tcphp_pkg::KIND_TSTAMP);
        hdr_q.push_back(8'd10);
        n = 8;
      end
      7: begin
        // Arbitrary kind with a short length.
        k = 8'($urandom_range(255));
        l = 8'($urandom_range(0, 12));
        hdr_q.push_back(k);
        hdr_q.push_back(l);
        n = (l > 2) ? l - 2 : 0;
      end
      8: begin
        // Known kind, usually with the wrong length.
        case ($urandom_range(4))
          0: k = tcphp_pkg::KIND_MSS;
          1: k = tcphp_pkg::KIND_WSCALE;
          2: k = tcphp_pkg::KIND_SPERM;
          3: k = tcphp_pkg::KIND_SACK;
          default: k = tcphp_pkg::KIND_TSTAMP;
        endcase
        l = 8'($urandom_range(0, 20));
        hdr_q.push_back(k);
        hdr_q.push_back(l);
        n = (l > 2) ? l - 2 : 0;
      end
      default: begin
        // Any length at all; long ones run past the header end.
        k = 8'($urandom_range(255));
        l = 8'($urandom_range(255));
        hdr_q.push_back(k);
        hdr_q.push_back(l);
        n = (l > 2) ? l - 2 : 0;
      end
    endcase
    repeat (n) hdr_q.push_back(8'($urandom_range(255)));
  endtask

  // Cuts or pads the built header to hdr_len bytes and sends it.
  task automatic finish_and_send(input int hdr_len);
    int p;
    while (hdr_q.size() > hdr_len) void'(hdr_q.pop_back());
    while (hdr_q.size() < hdr_len) begin
      p = $urandom_range(3);
      if (p == 0) hdr_q.push_back(tcphp_pkg::KIND_EOL);
      else if (p == 3) hdr_q.push_back(8'($urandom_range(255)));
      else hdr_q.push_back(tcphp_pkg::KIND_NOP);
    end
    foreach (hdr_q[i]) send_byte(hdr_q[i], i == 0);
    hdr_q.delete();
  endtask

  // One random header: mostly well formed, some short, truncated or cut off.
  task automatic send_random_header(input int opt_room, input bit plain);
    int r;
    int offs;
    int hdr_len;
    int sel;
    r = plain ? 50 : $urandom_range(99);
    hdr_q.delete();
    put_fixed($urandom_range(9));
    if (r < 8) begin
      offs = $urandom_range(0, 4);
    end else begin
      while (hdr_q.size() < 20 + opt_room) begin
        sel = $urandom_range(99);
        put_option(sel < 4 ? 9 : sel % 9);
      end
      if (r < 20) offs = $urandom_range(5, 15);
      else offs = (hdr_q.size() + 3) / 4 > 15 ? 15 : (hdr_q.size() + 3) / 4;
    end
    hdr_q[12] = {4'(offs), hdr_q[12][3:0]};
    hdr_len = (offs * 4 < 20) ? 20 : offs * 4;
    // A cut header is dropped when the next one starts.
    if (r >= 94) hdr_len = $urandom_range(1, hdr_len - 1);
    finish_and_send(hdr_len);
    // Stray bytes after the header.
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    int iter;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A byte with no header in progress is ignored.
    send_byte(8'hA5, 1'b0);

    // Longest header, all-ones fixed fields, one option of each flavor from 0 to 8.
    put_fixed(1);
    for (int s = 0; s <= 8; s++) put_option((s + 2) % 9);
    finish_and_send(60);

    // All-zero header with a data offset of zero.
    put_fixed(0);
    finish_and_send(20);

    // Header ends on an option kind byte.
    put_fixed(2);
    hdr_q[12] = {4'd6, hdr_q[12][3:0]};
    hdr_q.push_back(tcphp_pkg::KIND_NOP);
    hdr_q.push_back(tcphp_pkg::KIND_NOP);
    hdr_q.push_back(tcphp_pkg::KIND_NOP);
    hdr_q.push_back(tcphp_pkg::KIND_MSS);
    finish_and_send(24);

    // Header ends inside a timestamp value.
    put_fixed(2);
    hdr_q[12] = {4'd7, hdr_q[12][3:0]};
    hdr_q.push_back(tcphp_pkg::KIND_NOP);
    hdr_q.push_back(tcphp_pkg::KIND_NOP);
    put_option(6);
    finish_and_send(28);

    // New header start in the middle of a header.
    put_fixed(2);
    finish_and_send(9);
    put_fixed(2);
    hdr_q[12] = {4'd6, hdr_q[12][3:0]};
    put_option(2);
    finish_and_send(24);
    wait_drained();

    // Random headers.
    iter = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (iter == 8) begin
        -> hold_go;
        send_random_header(40, 1'b1);
      end else begin
        send_random_header($urandom_range(0, 40), 1'b0);
      end
      if (iter == 20) wait_drained();
      if (iter == 30) allow_idle = 1'b0;
      if (iter == 40) allow_idle = 1'b1;
      iter++;
    end

    // Let the last records out, then report.
    wait_drained();
    repeat (10) @(posedge clk);
    board.flush_leftovers();
    if (board.fail_count == 0) begin
      $display("tcp_header_parser_core test passed");
    end else begin
      $display("tcp_header_parser_core test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tcphp_pkg.sv
rtl/core/tcphp_step.sv
rtl/core/tcp_header_parser_core.sv
tb/tcp_header_parser_core_tb.sv
